// ----- rtl/ultrasonic_path_gain_sequencer_core_defines.svh -----
// assertion macros shared by the rtl files
`ifndef ULTRASONIC_PATH_GAIN_SEQUENCER_CORE_DEFINES_SVH
`define ULTRASONIC_PATH_GAIN_SEQUENCER_CORE_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define UPG_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define UPG_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/upg_pkg.sv -----
`default_nettype none
package upg_pkg;

   localparam int SLOT_COUNT    = 128;
   localparam int CAPTURE_LIMIT = 8;
   localparam int SLOT_W        = $clog2(SLOT_COUNT);
   localparam int LAST_SLOT     = SLOT_COUNT - 1;

   localparam logic [9:0] TARGET_RESET = 10'd465;

   // gains are q16
   localparam logic [18:0] ONE_Q16      = 19'd65536;
   localparam logic [18:0] MAX_GAIN_Q16 = 19'd262144;

   // shared serial divider
   localparam int DIV_DW = 38;
   localparam int DIV_SW = 19;
   localparam int DIV_CW = $clog2(DIV_DW + 1);

   // serial multiplier
   localparam int MCAND_W  = 25;
   localparam int MPLIER_W = 10;
   localparam int PROD_W   = MCAND_W + MPLIER_W;
   localparam int MUL_CW   = $clog2(MPLIER_W + 1);

   typedef enum logic [1:0] {
      REQ_START   = 2'd0,
      REQ_CROSS   = 2'd1,
      REQ_END     = 2'd2,
      REQ_ADVANCE = 2'd3
   } req_code_type;

   typedef struct packed {
      logic       start;
      logic [7:0] setting;
      logic [9:0] peak;
      logic [9:0] target;
   } gain_req_type;

   typedef struct packed {
      logic [6:0]  slot_index;
      logic [1:0]  path_index;
      logic [7:0]  digipot_value;
      logic [6:0]  capture_count;
      logic [9:0]  peak_amplitude;
      logic        set_done;
      logic [15:0] set_number;
   } rsp_payload_type;

endpackage
`default_nettype wire

// ----- rtl/upg_if.sv -----
`default_nettype none
interface upg_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        req_type;
   logic              zcd_level;
   logic signed [9:0] adc_sample;

   modport source (output valid, output req_type, output zcd_level, output adc_sample,
                   input ready);
   modport sink (input valid, input req_type, input zcd_level, input adc_sample,
                 output ready);
endinterface

interface upg_rsp_if;
   logic        valid;
   logic        ready;
   logic [6:0]  slot_index;
   logic [1:0]  path_index;
   logic [7:0]  digipot_value;
   logic [6:0]  capture_count;
   logic [9:0]  peak_amplitude;
   logic        set_done;
   logic [15:0] set_number;

   modport source (output valid, output slot_index, output path_index,
                   output digipot_value, output capture_count, output peak_amplitude,
                   output set_done, output set_number, input ready);
   modport sink (input valid, input slot_index, input path_index,
                 input digipot_value, input capture_count, input peak_amplitude,
                 input set_done, input set_number, output ready);
endinterface

interface upg_csr_if;
   logic       valid;
   logic       ready;
   logic [9:0] amp_goal;

   modport source (output valid, output amp_goal, input ready);
   modport sink (input valid, input amp_goal, output ready);
endinterface
`default_nettype wire

// ----- rtl/upg_serial_div.sv -----
`default_nettype none
`include "ultrasonic_path_gain_sequencer_core_defines.svh"
module upg_serial_div
   import upg_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIV_DW-1:0] dividend,
   input  logic [DIV_SW-1:0] divisor,
   input  logic [DIV_CW-1:0] step_count,
   output logic              done,
   output logic [DIV_DW-1:0] quotient
);

   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [DIV_CW-1:0] cnt_ff, cnt_in;
   logic [DIV_DW-1:0] dvd_ff, dvd_in;
   logic [DIV_SW-1:0] dvs_ff, dvs_in;
   logic [DIV_SW-1:0] rem_ff, rem_in;
   logic [DIV_DW-1:0] quo_ff, quo_in;

   logic [DIV_SW:0] trial;
   logic [DIV_SW:0] diff;
   logic            fits;

   // one quotient bit per cycle, dividend enters msb first
   assign trial = {rem_ff, dvd_ff[DIV_DW-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = step_count;
         dvd_in = dividend;
         dvs_in = divisor;
         rem_in = '0;
         quo_in = '0;
      end else if (run_ff) begin
         rem_in = fits ? diff[DIV_SW-1:0] : trial[DIV_SW-1:0];
         quo_in = {quo_ff[DIV_DW-2:0], fits};
         dvd_in = {dvd_ff[DIV_DW-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   `UPG_ASSERT_NOW(a_div_start_idle, start, !run_ff, "divider started while running")
   `UPG_ASSERT_NOW(a_div_done_after_run, done_ff, $past(run_ff), "divider done without a run")
   `UPG_ASSERT_NOW(a_div_rem_bound, run_ff, rem_ff < dvs_ff, "partial remainder not below divisor")

endmodule
`default_nettype wire

// ----- rtl/upg_serial_mul.sv -----
`default_nettype none
module upg_serial_mul
   import upg_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [MCAND_W-1:0]  multiplicand,
   input  logic [MPLIER_W-1:0] multiplier,
   output logic                done,
   output logic [PROD_W-1:0]   product
);

   logic                run_ff, run_in;
   logic                done_ff, done_in;
   logic [MUL_CW-1:0]   cnt_ff, cnt_in;
   logic [MCAND_W-1:0]  mcand_ff, mcand_in;
   logic [MPLIER_W-1:0] mplier_ff, mplier_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;

   // shift-add, multiplier bits msb first
   always_comb begin
      run_in    = run_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      prod_in   = prod_ff;
      if (start) begin
         run_in    = 1'b1;
         cnt_in    = MUL_CW'(MPLIER_W);
         mcand_in  = multiplicand;
         mplier_in = multiplier;
         prod_in   = '0;
      end else if (run_ff) begin
         prod_in   = {prod_ff[PROD_W-2:0], 1'b0}
                     + (mplier_ff[MPLIER_W-1] ? PROD_W'(mcand_ff) : '0);
         mplier_in = {mplier_ff[MPLIER_W-2:0], 1'b0};
         cnt_in    = cnt_ff - 1'b1;
         if (cnt_ff == MUL_CW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      prod_ff   <= prod_in;
   end

   assign done    = done_ff;
   assign product = prod_ff;

endmodule
`default_nettype wire

// ----- rtl/upg_gain_loop.sv -----
`default_nettype none
module upg_gain_loop
   import upg_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  gain_req_type gain_req,
   output logic         done,
   output logic [7:0]   setting
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_OLD_GO,
      ST_OLD_WAIT,
      ST_MUL_GO,
      ST_MUL_WAIT,
      ST_RAW_GO,
      ST_RAW_WAIT,
      ST_SUM_A,
      ST_SUM_B,
      ST_SUM_C,
      ST_TEN_GO,
      ST_TEN_WAIT,
      ST_CLAMP,
      ST_SET_GO,
      ST_SET_WAIT
   } state_type;

   localparam logic [DIV_CW-1:0] OLD_STEPS = DIV_CW'(25);
   localparam logic [DIV_CW-1:0] RAW_STEPS = DIV_CW'(PROD_W);
   localparam logic [DIV_CW-1:0] TEN_STEPS = DIV_CW'(DIV_DW);
   localparam logic [DIV_CW-1:0] SET_STEPS = DIV_CW'(27);
   localparam logic [DIV_SW-1:0] TEN       = DIV_SW'(10);

   state_type           state_ff, state_in;
   logic [7:0]          d_ff, d_in;
   logic [9:0]          peak_ff, peak_in;
   logic [9:0]          target_ff, target_in;
   logic [MCAND_W-1:0]  old_ff, old_in;
   logic [DIV_DW-1:0]   acc_ff, acc_in;
   logic [18:0]         g_ff, g_in;
   logic                done_ff, done_in;
   logic [7:0]          setting_ff, setting_in;

   logic              div_start;
   logic [DIV_DW-1:0] div_dividend;
   logic [DIV_SW-1:0] div_divisor;
   logic [DIV_CW-1:0] div_steps;
   logic              div_done;
   logic [DIV_DW-1:0] div_quotient;
   logic              mul_start;
   logic              mul_done;
   logic [PROD_W-1:0] mul_product;

   upg_serial_div u_div (
      .clock      (clock),
      .reset      (reset),
      .start      (div_start),
      .dividend   (div_dividend),
      .divisor    (div_divisor),
      .step_count (div_steps),
      .done       (div_done),
      .quotient   (div_quotient)
   );

   upg_serial_mul u_mul (
      .clock        (clock),
      .reset        (reset),
      .start        (mul_start),
      .multiplicand (old_ff),
      .multiplier   (target_ff),
      .done         (mul_done),
      .product      (mul_product)
   );

   always_comb begin
      state_in     = state_ff;
      d_in         = d_ff;
      peak_in      = peak_ff;
      target_in    = target_ff;
      old_in       = old_ff;
      acc_in       = acc_ff;
      g_in         = g_ff;
      done_in      = 1'b0;
      setting_in   = setting_ff;
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;
      div_steps    = '0;
      mul_start    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (gain_req.start) begin
               d_in      = gain_req.setting;
               peak_in   = gain_req.peak;
               target_in = gain_req.target;
               state_in  = ST_OLD_GO;
            end
         end
         ST_OLD_GO: begin
            // 2^24 / (256 - d), dividend msb aligned
            div_start    = 1'b1;
            div_dividend = {1'b1, {(DIV_DW-1){1'b0}}};
            div_divisor  = DIV_SW'(9'd256 - {1'b0, d_ff});
            div_steps    = OLD_STEPS;
            state_in     = ST_OLD_WAIT;
         end
         ST_OLD_WAIT: begin
            if (div_done) begin
               old_in = div_quotient[MCAND_W-1:0];
               if (peak_ff == '0) begin
                  g_in     = MAX_GAIN_Q16;
                  state_in = ST_SET_GO;
               end else begin
                  state_in = ST_MUL_GO;
               end
            end
         end
         ST_MUL_GO: begin
            mul_start = 1'b1;
            state_in  = ST_MUL_WAIT;
         end
         ST_MUL_WAIT: begin
            if (mul_done) begin
               state_in = ST_RAW_GO;
            end
         end
         ST_RAW_GO: begin
            div_start    = 1'b1;
            div_dividend = {mul_product, {(DIV_DW-PROD_W){1'b0}}};
            div_divisor  = DIV_SW'(peak_ff);
            div_steps    = RAW_STEPS;
            state_in     = ST_RAW_WAIT;
         end
         ST_RAW_WAIT: begin
            if (div_done) begin
               acc_in   = div_quotient;
               state_in = ST_SUM_A;
            end
         end
         ST_SUM_A: begin
            acc_in   = acc_ff + {acc_ff[DIV_DW-2:0], 1'b0};
            state_in = ST_SUM_B;
         end
         ST_SUM_B: begin
            acc_in   = acc_ff + DIV_DW'({old_ff, 3'b000});
            state_in = ST_SUM_C;
         end
         ST_SUM_C: begin
            acc_in   = acc_ff - DIV_DW'(old_ff);
            state_in = ST_TEN_GO;
         end
         ST_TEN_GO: begin
            div_start    = 1'b1;
            div_dividend = acc_ff;
            div_divisor  = TEN;
            div_steps    = TEN_STEPS;
            state_in     = ST_TEN_WAIT;
         end
         ST_TEN_WAIT: begin
            if (div_done) begin
               acc_in   = div_quotient;
               state_in = ST_CLAMP;
            end
         end
         ST_CLAMP: begin
            if (acc_ff > DIV_DW'(MAX_GAIN_Q16)) begin
               g_in = MAX_GAIN_Q16;
            end else if (acc_ff < DIV_DW'(ONE_Q16)) begin
               g_in = ONE_Q16;
            end else begin
               g_in = acc_ff[18:0];
            end
            state_in = ST_SET_GO;
         end
         ST_SET_GO: begin
            // 256 * (g - 1.0) / g
            div_start    = 1'b1;
            div_dividend = {g_ff - ONE_Q16, 8'd0, {(DIV_DW-27){1'b0}}};
            div_divisor  = g_ff;
            div_steps    = SET_STEPS;
            state_in     = ST_SET_WAIT;
         end
         ST_SET_WAIT: begin
            if (div_done) begin
               setting_in = div_quotient[7:0];
               done_in    = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      d_ff       <= d_in;
      peak_ff    <= peak_in;
      target_ff  <= target_in;
      old_ff     <= old_in;
      acc_ff     <= acc_in;
      g_ff       <= g_in;
      setting_ff <= setting_in;
   end

   assign done    = done_ff;
   assign setting = setting_ff;

endmodule
`default_nettype wire

// ----- rtl/ultrasonic_path_gain_sequencer_core.sv -----
`default_nettype none
// Slot sequencer and per-path automatic gain loop for four ultrasonic paths.
// Start window, zero crossing and advance slot items give a result that passes
// through a pending register and then the output register, and a new item is
// taken only once the previous result has left the pending register.
// An end measurement item runs the gain update on one shared bit-serial
// divider (four divisions of 25, 35, 38 and 27 steps) and a 10-step serial
// multiplier, or only the first and last divisions when the peak is zero; the
// next item is accepted once the update's result has moved to the output stage.
// The output register holds a finished result while the next item is taken.
// The target peak amplitude is written through the csr channel; the user must
// write it only while the block is idle, the block itself does not enforce this.
`include "ultrasonic_path_gain_sequencer_core_defines.svh"
module ultrasonic_path_gain_sequencer_core
   import upg_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   upg_req_if.sink    req_if,
   upg_rsp_if.source  rsp_if,
   upg_csr_if.sink    csr_if
);

   logic [9:0]        target_ff, target_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [7:0]        table_ff [4];
   logic [7:0]        table_in [4];
   logic [7:0]        active_ff, active_in;
   logic [6:0]        count_ff, count_in;
   logic [9:0]        peak_ff, peak_in;
   logic [15:0]       setcnt_ff, setcnt_in;
   logic              busy_ff, busy_in;
   logic              pend_valid_ff, pend_valid_in;
   rsp_payload_type   pend_ff, pend_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_payload_type   rsp_ff, rsp_in;

   logic              req_fire;
   logic [9:0]        mag;
   logic [SLOT_W-1:0] slot_next;
   logic              last_slot;
   gain_req_type      gain_req;
   logic              gain_done;
   logic [7:0]        gain_setting;

   assign req_if.ready = !busy_ff && !pend_valid_ff;
   assign req_fire     = req_if.valid && req_if.ready;
   assign csr_if.ready = 1'b1;

   // absolute sample, most negative code gives 512
   assign mag       = req_if.adc_sample[9] ? (~req_if.adc_sample + 10'd1)
                                           : req_if.adc_sample;
   assign slot_next = (slot_ff == SLOT_W'(LAST_SLOT)) ? '0 : slot_ff + 1'b1;
   assign last_slot = slot_ff == SLOT_W'(LAST_SLOT);

   upg_gain_loop u_gain (
      .clock    (clock),
      .reset    (reset),
      .gain_req (gain_req),
      .done     (gain_done),
      .setting  (gain_setting)
   );

   always_comb begin
      target_in     = target_ff;
      slot_in       = slot_ff;
      table_in      = table_ff;
      active_in     = active_ff;
      count_in      = count_ff;
      peak_in       = peak_ff;
      setcnt_in     = setcnt_ff;
      busy_in       = busy_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      gain_req      = '{start: 1'b0, setting: active_ff, peak: peak_ff, target: target_ff};

      if (csr_if.valid) begin
         target_in = csr_if.amp_goal;
      end

      // output stage
      if (!rsp_valid_ff || rsp_if.ready) begin
         rsp_valid_in  = pend_valid_ff;
         pend_valid_in = 1'b0;
         if (pend_valid_ff) begin
            rsp_in = pend_ff;
         end
      end

      if (req_fire) begin
         case (req_code_type'(req_if.req_type))
            REQ_START: begin
               count_in = '0;
               peak_in  = '0;
            end
            REQ_CROSS: begin
               if (count_ff < 7'(CAPTURE_LIMIT)) begin
                  if (count_ff != '0) begin
                     if (mag > peak_ff) begin
                        peak_in = mag;
                     end
                     count_in = count_ff + 7'd1;
                  end else if (req_if.zcd_level) begin
                     // first crossing only arms on a high pin
                     count_in = 7'd1;
                  end
               end
            end
            REQ_END: begin
               busy_in        = 1'b1;
               gain_req.start = 1'b1;
            end
            REQ_ADVANCE: begin
               slot_in   = slot_next;
               active_in = table_ff[slot_next[1:0]];
            end
            default: begin
               busy_in = busy_ff;
            end
         endcase
         if (req_code_type'(req_if.req_type) != REQ_END) begin
            pend_valid_in = 1'b1;
            pend_in = '{slot_index:     7'(slot_in),
                        path_index:     slot_in[1:0],
                        digipot_value:  active_in,
                        capture_count:  count_in,
                        peak_amplitude: peak_in,
                        set_done:       1'b0,
                        set_number:     setcnt_ff};
         end
      end

      if (gain_done) begin
         busy_in                = 1'b0;
         table_in[slot_ff[1:0]] = gain_setting;
         if (last_slot) begin
            setcnt_in = setcnt_ff + 16'd1;
         end
         pend_valid_in = 1'b1;
         pend_in = '{slot_index:     7'(slot_ff),
                     path_index:     slot_ff[1:0],
                     digipot_value:  gain_setting,
                     capture_count:  count_ff,
                     peak_amplitude: peak_ff,
                     set_done:       last_slot,
                     set_number:     setcnt_in};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff     <= TARGET_RESET;
         slot_ff       <= '0;
         table_ff      <= '{default: '0};
         active_ff     <= '0;
         count_ff      <= '0;
         peak_ff       <= '0;
         setcnt_ff     <= '0;
         busy_ff       <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         target_ff     <= target_in;
         slot_ff       <= slot_in;
         table_ff      <= table_in;
         active_ff     <= active_in;
         count_ff      <= count_in;
         peak_ff       <= peak_in;
         setcnt_ff     <= setcnt_in;
         busy_ff       <= busy_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.slot_index     = rsp_ff.slot_index;
   assign rsp_if.path_index     = rsp_ff.path_index;
   assign rsp_if.digipot_value  = rsp_ff.digipot_value;
   assign rsp_if.capture_count  = rsp_ff.capture_count;
   assign rsp_if.peak_amplitude = rsp_ff.peak_amplitude;
   assign rsp_if.set_done       = rsp_ff.set_done;
   assign rsp_if.set_number     = rsp_ff.set_number;

   `UPG_ASSERT_NOW(a_gain_done_busy, gain_done, busy_ff, "gain update finished while not busy")
   `UPG_ASSERT_NEXT(a_item_held, req_fire, pend_valid_ff || busy_ff, "accepted item dropped")
   `UPG_ASSERT_NOW(a_set_done_last, rsp_if.valid && rsp_if.set_done, rsp_if.slot_index == 7'(LAST_SLOT), "set done outside last slot")
   `UPG_ASSERT_NOW(a_count_limit, 1'b1, count_ff <= 7'(CAPTURE_LIMIT), "crossing count past limit")

endmodule
`default_nettype wire

// ----- dv/ultrasonic_path_gain_sequencer_core_tb.sv -----
`timescale 1ns / 1ps
module ultrasonic_path_gain_sequencer_core_tb;
   import upg_pkg::*;

   class gain_loop_scoreboard;
      logic [9:0]      target;
      int              slot;
      logic [7:0]      setting_tbl [4];
      logic [7:0]      active;
      int              crossings;
      logic [9:0]      peak;
      logic [15:0]     set_counter;
      rsp_payload_type slot_reports_q [$];
      int              fail_count;

      function new();
         target      = TARGET_RESET;
         slot        = 0;
         active      = '0;
         crossings   = 0;
         peak        = '0;
         set_counter = '0;
         fail_count  = 0;
         foreach (setting_tbl[i]) setting_tbl[i] = '0;
      endfunction

      function void set_target(logic [9:0] value);
         target = value;
      endfunction

      function int pending();
         return slot_reports_q.size();
      endfunction

      function void report(string msg);
         fail_count++;
         if (fail_count <= 10) $display("%s", msg);
      endfunction

      // q16 gain loop, all divisions truncate
      function logic [7:0] updated_setting(logic [7:0] d, logic [9:0] pk, logic [9:0] tgt);
         logic [63:0] old_gain;
         logic [63:0] raw_gain;
         logic [63:0] g;
         old_gain = (64'd256 << 16) / (64'd256 - 64'(d));
         if (pk == '0) begin
            g = 64'(MAX_GAIN_Q16);
         end else begin
            raw_gain = old_gain * 64'(tgt) / 64'(pk);
            g = (64'd3 * raw_gain + 64'd7 * old_gain) / 64'd10;
            if (g > 64'(MAX_GAIN_Q16)) g = 64'(MAX_GAIN_Q16);
            if (g < 64'(ONE_Q16)) g = 64'(ONE_Q16);
         end
         return 8'((64'd256 * (g - 64'(ONE_Q16))) / g);
      endfunction

      function void note_item(req_code_type kind, logic lvl, logic signed [9:0] sample);
         rsp_payload_type want;
         int              sv;
         logic [9:0]      mag;
         logic [7:0]      dig;
         logic            done;
         sv   = sample;
         mag  = 10'((sv < 0) ? -sv : sv);
         dig  = active;
         done = 1'b0;
         case (kind)
            REQ_START: begin
               crossings = 0;
               peak      = '0;
            end
            REQ_CROSS: begin
               // first crossing only arms the count, its sample is stale
               if (crossings < CAPTURE_LIMIT) begin
                  if (crossings != 0) begin
                     if (mag > peak) peak = mag;
                     crossings++;
                  end else if (lvl) begin
                     crossings = 1;
                  end
               end
            end
            REQ_END: begin
               dig = updated_setting(active, peak, target);
               setting_tbl[slot % 4] = dig;
               if (slot == LAST_SLOT) begin
                  set_counter++;
                  done = 1'b1;
               end
            end
            default: begin
               slot   = (slot + 1 >= SLOT_COUNT) ? 0 : slot + 1;
               active = setting_tbl[slot % 4];
               dig    = active;
            end
         endcase
         want.slot_index     = 7'(slot);
         want.path_index     = 2'(slot % 4);
         want.digipot_value  = dig;
         want.capture_count  = 7'(crossings);
         want.peak_amplitude = peak;
         want.set_done       = done;
         want.set_number     = set_counter;
         slot_reports_q.push_back(want);
      endfunction

      function void check_result(rsp_payload_type got);
         rsp_payload_type want;
         bit              bad;
         if (slot_reports_q.size() == 0) begin
            report($sformatf("unexpected result item %p", got));
            return;
         end
         want = slot_reports_q.pop_front();
         bad = (got.slot_index !== want.slot_index) ||
               (got.path_index !== want.path_index) ||
               (got.digipot_value !== want.digipot_value) ||
               (got.capture_count !== want.capture_count) ||
               (got.peak_amplitude !== want.peak_amplitude) ||
               (got.set_done !== want.set_done) ||
               (got.set_number !== want.set_number);
         if (bad) report($sformatf("mismatch: expected %p actual %p", want, got));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   upg_req_if req_ch ();
   upg_rsp_if rsp_ch ();
   upg_csr_if csr_ch ();

   gain_loop_scoreboard sb = new();

   int items_sent = 0;
   bit idle_on    = 1'b1;
   bit hold_rsp   = 1'b0;

   always #5 clock = ~clock;

   ultrasonic_path_gain_sequencer_core u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   function automatic logic [9:0] pick_sample();
      int m;
      if ($urandom_range(0, 3) == 0) begin
         m = $urandom_range(0, 40);
         return ($urandom_range(0, 1) == 1) ? 10'(-m) : 10'(m);
      end
      return 10'($urandom_range(0, 1023));
   endfunction

   task automatic send_item(req_code_type kind, logic lvl, logic [9:0] sample);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.req_type   <= kind;
      req_ch.zcd_level  <= lvl;
      req_ch.adc_sample <= sample;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_item(kind, lvl, sample);
      items_sent++;
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_target(logic [9:0] value);
      wait_drained();
      csr_ch.valid    <= 1'b1;
      csr_ch.amp_goal <= value;
      do @(posedge clock); while (!csr_ch.ready);
      sb.set_target(value);
      csr_ch.valid <= 1'b0;
   endtask

   // walk up to the last slot, finish a measurement there, then wrap
   task automatic run_to_last_slot();
      while (sb.slot != LAST_SLOT)
         send_item(REQ_ADVANCE, 1'($urandom_range(0, 1)), pick_sample());
      send_item(REQ_START, 1'b1, pick_sample());
      send_item(REQ_CROSS, 1'b1, pick_sample());
      send_item(REQ_CROSS, 1'b0, -10'sd200);
      send_item(REQ_END, 1'b0, pick_sample());
      send_item(REQ_ADVANCE, 1'b0, pick_sample());
   endtask

   task automatic run_random(int goal);
      int stop_at;
      int roll;
      int n;
      stop_at = items_sent + goal;
      while (items_sent < stop_at) begin
         roll = $urandom_range(0, 99);
         if (roll < 40) begin
            send_item(REQ_ADVANCE, 1'($urandom_range(0, 1)), pick_sample());
         end else if (roll < 90) begin
            // well-formed measurement: window, crossings, gain update, next slot
            send_item(REQ_START, 1'($urandom_range(0, 1)), pick_sample());
            n = $urandom_range(0, 9);
            for (int i = 0; i < n; i++)
               send_item(REQ_CROSS, (i == 0) ? 1'($urandom_range(0, 7) != 0) :
                         1'($urandom_range(0, 1)), pick_sample());
            send_item(REQ_END, 1'($urandom_range(0, 1)), pick_sample());
            send_item(REQ_ADVANCE, 1'($urandom_range(0, 1)), pick_sample());
         end else begin
            send_item(req_code_type'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                      pick_sample());
         end
      end
   endtask

   // result side: random stalls plus one long hold-off on request
   initial begin : rsp_side
      int              stall_left;
      int              hold_left;
      rsp_payload_type got;
      stall_left = 0;
      hold_left  = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            got.slot_index     = rsp_ch.slot_index;
            got.path_index     = rsp_ch.path_index;
            got.digipot_value  = rsp_ch.digipot_value;
            got.capture_count  = rsp_ch.capture_count;
            got.peak_amplitude = rsp_ch.peak_amplitude;
            got.set_done       = rsp_ch.set_done;
            got.set_number     = rsp_ch.set_number;
            sb.check_result(got);
         end
         if (hold_rsp) begin
            hold_rsp  = 1'b0;
            hold_left = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 8) - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   initial begin
      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.req_type   <= REQ_START;
      req_ch.zcd_level  <= 1'b0;
      req_ch.adc_sample <= '0;
      csr_ch.valid      <= 1'b0;
      csr_ch.amp_goal   <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: pin low on first crossing, sample extremes, capture limit,
      // zero peak, crossing after the window closed, path reload on advance
      send_item(REQ_START, 1'b0, 10'd0);
      send_item(REQ_CROSS, 1'b0, 10'sd511);
      send_item(REQ_CROSS, 1'b1, -10'sd512);
      send_item(REQ_CROSS, 1'b0, -10'sd512);
      send_item(REQ_CROSS, 1'b1, 10'sd511);
      send_item(REQ_CROSS, 1'b0, 10'sd0);
      send_item(REQ_CROSS, 1'b1, -10'sd1);
      send_item(REQ_CROSS, 1'b0, 10'sd100);
      send_item(REQ_CROSS, 1'b1, -10'sd300);
      send_item(REQ_CROSS, 1'b1, 10'sd7);
      send_item(REQ_CROSS, 1'b1, -10'sd512);
      send_item(REQ_END, 1'b0, 10'sd0);
      send_item(REQ_CROSS, 1'b1, 10'sd50);
      send_item(REQ_ADVANCE, 1'b1, 10'sd511);
      send_item(REQ_START, 1'b1, -10'sd512);
      send_item(REQ_END, 1'b1, 10'sd0);
      send_item(REQ_CROSS, 1'b1, 10'sd20);
      send_item(REQ_CROSS, 1'b0, 10'sd30);
      send_item(REQ_ADVANCE, 1'b0, 10'sd0);
      send_item(REQ_ADVANCE, 1'b0, 10'sd0);
      send_item(REQ_ADVANCE, 1'b0, 10'sd0);
      send_item(REQ_START, 1'b0, 10'sd0);
      send_item(REQ_END, 1'b0, 10'sd0);
      send_item(REQ_ADVANCE, 1'b0, 10'sd0);
      run_to_last_slot();

      write_target(10'd1023);
      run_random(110);
      write_target(10'd0);
      run_random(60);
      // long receiver hold while items keep coming
      hold_rsp = 1'b1;
      run_random(90);
      write_target(10'd1);
      run_random(130);
      write_target(10'($urandom_range(2, 1022)));
      run_random(130);
      write_target(10'd465);
      run_random(130);
      idle_on = 1'b0;
      run_random(130);

      wait_drained();
      repeat (200) @(posedge clock);
      if (sb.pending() != 0)
         sb.report($sformatf("%0d result items never arrived", sb.pending()));
      if (sb.fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
